### rtl/core/nrc_pkg.sv
// Shared widths, constants and controller/datapath types for the nonce replay cache.
package nrc_pkg;

    localparam int NONCE_W = 64;
    localparam int TIME_W  = 32;
    localparam int TTL_W   = 16;
    localparam int SLOT_W  = 6;

    localparam logic [TTL_W-1:0] TTL_RESET = 16'd300;

    // One stored slot: nonce and its expiry time
    typedef struct packed {
        logic [NONCE_W-1:0] nonce;
        logic [TIME_W-1:0]  expiry;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;     // latch a new item, clear hit flag and scan counter
        logic issue_read;  // read the slot under the scan counter
        logic commit;      // record the nonce on a miss and load the result
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic fill_empty;  // no slot written since reset
        logic last_issue;  // scan counter is on the last filled slot
        logic hit;         // a live match was seen so far
    } status_t;

endpackage

### rtl/core/nrc_channel_if.sv
// Handshake channel interfaces: request, response and ttl configuration.
interface nrc_req_if
    import nrc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [NONCE_W-1:0] nonce_value;
    logic [TIME_W-1:0]  time_now;

    modport source (output valid, output nonce_value, output time_now, input ready);
    modport sink   (input valid, input nonce_value, input time_now, output ready);
endinterface

interface nrc_rsp_if
    import nrc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              is_replay;
    logic [SLOT_W-1:0] slot_used;

    modport source (output valid, output is_replay, output slot_used, input ready);
    modport sink   (input valid, input is_replay, input slot_used, output ready);
endinterface

interface nrc_cfg_if
    import nrc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [TTL_W-1:0] ttl_seconds;

    modport source (output valid, output ttl_seconds, input ready);
    modport sink   (input valid, input ttl_seconds, output ready);
endinterface

### rtl/core/nrc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/nrc_datapath.sv
// Datapath: slot store, sequential compare scan, write pointer, fill count, result register.
module nrc_datapath
    import nrc_pkg::*;
#(
    parameter int CACHE_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output status_t            sts,
    input  logic [NONCE_W-1:0] nonce_in,
    input  logic [TIME_W-1:0]  time_in,
    input  logic               cfg_we,
    input  logic [TTL_W-1:0]   cfg_ttl,
    output logic               is_replay,
    output logic [SLOT_W-1:0]  slot_used
);

    localparam int ADDR_W = $clog2(CACHE_DEPTH);
    localparam int FILL_W = $clog2(CACHE_DEPTH + 1);

    logic [TTL_W-1:0]   ttl_reg, ttl_next;
    logic               hit_reg, hit_next;
    logic               rd_valid_reg;
    logic [FILL_W-1:0]  scan_reg, scan_next;
    logic [ADDR_W-1:0]  wp_reg, wp_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [NONCE_W-1:0] nonce_reg;
    logic [TIME_W-1:0]  time_reg;
    logic               is_replay_reg;
    logic [SLOT_W-1:0]  slot_reg;

    logic [ENTRY_W-1:0] rd_data;
    entry_t             rd_entry;
    entry_t             wr_entry;
    logic               match;
    logic               store_new;
    logic [TIME_W:0]    exp_sum;
    logic [TIME_W-1:0]  expiry;
    logic [SLOT_W+ADDR_W-1:0] slot_wide;

    // Slot store: one word per slot, nonce and expiry together
    nrc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CACHE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (store_new),
        .waddr (wp_reg),
        .wdata (wr_entry),
        .re    (cmd.issue_read),
        .raddr (scan_reg[ADDR_W-1:0]),
        .rdata (rd_data)
    );

    // Compare of the slot read in the previous cycle
    assign rd_entry = entry_t'(rd_data);
    assign match    = (rd_entry.expiry > time_reg) && (rd_entry.nonce == nonce_reg);

    // Expiry = now + ttl, saturated at the top of the time range
    assign exp_sum  = {1'b0, time_reg} + {{(TIME_W + 1 - TTL_W){1'b0}}, ttl_reg};
    assign expiry   = exp_sum[TIME_W] ? {TIME_W{1'b1}} : exp_sum[TIME_W-1:0];
    assign wr_entry = '{nonce: nonce_reg, expiry: expiry};

    assign store_new = cmd.commit && !hit_reg;
    assign slot_wide = {{SLOT_W{1'b0}}, wp_reg};

    // Next-state logic for control registers
    always_comb
    begin
        ttl_next  = cfg_we ? cfg_ttl : ttl_reg;
        hit_next  = hit_reg;
        scan_next = scan_reg;
        wp_next   = wp_reg;
        fill_next = fill_reg;
        if (cmd.capture)
        begin
            hit_next  = 1'b0;
            scan_next = '0;
        end
        else
        begin
            if (rd_valid_reg && match)
            begin
                hit_next = 1'b1;
            end
            if (cmd.issue_read)
            begin
                scan_next = scan_reg + FILL_W'(1);
            end
        end
        if (store_new)
        begin
            wp_next = (wp_reg == ADDR_W'(CACHE_DEPTH - 1)) ? '0 : wp_reg + ADDR_W'(1);
            if (fill_reg != FILL_W'(CACHE_DEPTH))
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg      <= TTL_RESET;
            hit_reg      <= 1'b0;
            rd_valid_reg <= 1'b0;
            scan_reg     <= '0;
            wp_reg       <= '0;
            fill_reg     <= '0;
        end
        else
        begin
            ttl_reg      <= ttl_next;
            hit_reg      <= hit_next;
            rd_valid_reg <= cmd.issue_read;
            scan_reg     <= scan_next;
            wp_reg       <= wp_next;
            fill_reg     <= fill_next;
        end
    end

    // Item and result payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            nonce_reg <= nonce_in;
            time_reg  <= time_in;
        end
        if (cmd.commit)
        begin
            is_replay_reg <= hit_reg;
            slot_reg      <= slot_wide[SLOT_W-1:0];
        end
    end

    assign is_replay = is_replay_reg;
    assign slot_used = slot_reg;

    assign sts.fill_empty = (fill_reg == '0);
    assign sts.last_issue = (scan_reg == fill_reg - FILL_W'(1));
    assign sts.hit        = hit_reg;

endmodule

### rtl/core/nrc_ctrl.sv
// Controller: sequences capture, slot scan, decision and result handshake.
module nrc_ctrl
    import nrc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t sts,
    output cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    // State transitions and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = sts.fill_empty ? ST_DECIDE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.issue_read = 1'b1;
                if (sts.last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid: set on commit, cleared when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/core/nonce_replay_cache.sv
// Nonce replay cache top level: controller, datapath and ports.
//
// req carries nonce_value and time_now; rsp returns is_replay and slot_used,
// one item per request; cfg writes ttl_seconds (always ready, reset 300).
// Each request is compared against every slot written so far. The slots sit
// in one RAM with a single read port, so the scan reads one slot per cycle.
// With N slots filled (N >= 1, saturating at CACHE_DEPTH) a request passes
// through the scan, a drain state and the decide state before its result is
// valid, and no new request is taken until that result is loaded. An empty
// cache skips the scan and the drain state and goes straight to decide.
// A miss records the nonce with expiry time_now + ttl (saturated) at the
// round-robin write pointer; a replay changes nothing.
// Reset empties the cache at once: a fill count marks which slots hold data,
// so no clearing pass is needed and the block takes items right away.
// The result sits in an output register; one new request can be taken while
// it waits, but that request holds in its final cycle until the result
// register is free, and req.ready stays low meanwhile.
module nonce_replay_cache
    import nrc_pkg::*;
#(
    parameter int CACHE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    nrc_req_if.sink     req,
    nrc_rsp_if.source   rsp,
    nrc_cfg_if.sink     cfg
);

    cmd_t    cmd;
    status_t sts;

    assign cfg.ready = 1'b1;

    // Sequencer
    nrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Store, scan and result
    nrc_datapath #(
        .CACHE_DEPTH (CACHE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .nonce_in  (req.nonce_value),
        .time_in   (req.time_now),
        .cfg_we    (cfg.valid),
        .cfg_ttl   (cfg.ttl_seconds),
        .is_replay (rsp.is_replay),
        .slot_used (rsp.slot_used)
    );

`ifndef NO_ASSERTIONS
    // No second request is taken while one is being worked on
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while busy");

    // Scan reads only happen when some slot holds data
    a_scan_filled: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue_read |-> !sts.fill_empty)
        else $error("scan read with empty cache");

    // Recording a miss leaves the cache non-empty
    a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !sts.hit) |=> !sts.fill_empty)
        else $error("fill count not advanced on record");

    // A result is only loaded when the output register is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!rsp.valid || rsp.ready))
        else $error("result overwritten before taken");
`endif

endmodule

### tb/tb_nonce_replay_cache.sv
// Self-checking testbench for the nonce replay cache: directed and random requests.
module tb_nonce_replay_cache
    import nrc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CACHE_SLOTS = 64;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 80;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 92;
    localparam int POOL_DEPTH = 96;

    // One expected response
    typedef struct packed {
        logic              is_replay;
        logic [SLOT_W-1:0] slot_used;
    } verdict_t;

    // Mirror of the cache contents; predicts one verdict per request
    class replay_tracker;
        logic [NONCE_W-1:0] nonce_mem [CACHE_SLOTS];
        logic [TIME_W-1:0]  expiry_mem [CACHE_SLOTS];
        int unsigned        wr_ptr;
        logic [TTL_W-1:0]   ttl;
        verdict_t           expected_verdicts [$];
        int                 errors;

        function new();
            foreach (nonce_mem[i])
            begin
                nonce_mem[i] = '0;
                expiry_mem[i] = '0;
            end
            wr_ptr = 0;
            ttl = TTL_RESET;
            errors = 0;
        endfunction

        // Accepted request: compare against live slots, record on a miss
        function void record_request(logic [NONCE_W-1:0] nonce, logic [TIME_W-1:0] now);
            logic          hit;
            logic [TIME_W:0] sum;
            verdict_t      v;
            hit = 1'b0;
            for (int i = 0; i < CACHE_SLOTS; i++)
            begin
                if (expiry_mem[i] > now && nonce_mem[i] == nonce)
                    hit = 1'b1;
            end
            v.is_replay = hit;
            v.slot_used = SLOT_W'(wr_ptr);
            if (!hit)
            begin
                sum = {1'b0, now} + {17'd0, ttl};
                nonce_mem[wr_ptr] = nonce;
                expiry_mem[wr_ptr] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                wr_ptr = (wr_ptr == CACHE_SLOTS - 1) ? 0 : wr_ptr + 1;
            end
            expected_verdicts.push_back(v);
        endfunction

        // Accepted response: compare with the oldest prediction
        function void check_response(logic is_replay, logic [SLOT_W-1:0] slot_used);
            verdict_t want;
            if (expected_verdicts.size() == 0)
            begin
                $display("%0t: unexpected response is_replay=%0b slot_used=%0d",
                         $time, is_replay, slot_used);
                errors++;
                return;
            end
            want = expected_verdicts.pop_front();
            if (is_replay !== want.is_replay)
            begin
                $display("%0t: is_replay expected %0b actual %0b",
                         $time, want.is_replay, is_replay);
                errors++;
            end
            if (slot_used !== want.slot_used)
            begin
                $display("%0t: slot_used expected %0d actual %0d",
                         $time, want.slot_used, slot_used);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    nrc_req_if req_ch ();
    nrc_rsp_if rsp_ch ();
    nrc_cfg_if cfg_ch ();

    replay_tracker tracker = new();

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    wire any_accept = (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                      || (cfg_ch.valid && cfg_ch.ready);

    nonce_replay_cache #(
        .CACHE_DEPTH (CACHE_SLOTS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Response side: random backpressure and checking
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            tracker.check_response(rsp_ch.is_replay, rsp_ch.slot_used);
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: too long without any handshake ends the run
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (any_accept)
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Present one request, with random idle cycles ahead of it
    task automatic send_request(input logic [NONCE_W-1:0] nonce, input logic [TIME_W-1:0] now);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.nonce_value <= nonce;
        req_ch.time_now <= now;
        do
            @(posedge clk);
        while (!req_ch.ready);
        tracker.record_request(nonce, now);
    endtask

    // Stop sending and wait for every outstanding response
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (tracker.expected_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_ttl(input logic [TTL_W-1:0] ttl);
        cfg_ch.valid <= 1'b1;
        cfg_ch.ttl_seconds <= ttl;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        tracker.ttl = ttl;
    endtask

    initial
    begin : stimulus
        int unsigned        phase_ttl [PHASES] = '{20, 1, 65535, 0, 300, 7};
        int unsigned        phase_idle [PHASES] = '{0, 79, 0, 34, 0, 79};
        int unsigned        phase_stall [PHASES] = '{0, 0, 79, 34, 0, 0};
        logic [NONCE_W-1:0] recent_nonces [$];
        logic [NONCE_W-1:0] n;
        logic [TIME_W-1:0]  t;
        logic [TIME_W-1:0]  wall_clock;
        int unsigned        r;

        req_ch.valid <= 1'b0;
        req_ch.nonce_value <= '0;
        req_ch.time_now <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.ttl_seconds <= TTL_RESET;
        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset lifetime; empty slots never match, even for nonce zero
        send_request(64'd0, 32'd0);
        send_request(64'd0, 32'd0);
        send_request(64'd0, 32'd299);
        // expiry equal to the current time no longer matches
        send_request(64'd0, 32'd300);
        // expiry saturates at the top of the time range
        send_request('1, '1);
        send_request('1, 32'hFFFF_FFFE);
        send_request('1, '1);
        // time going backwards still hits
        send_request(64'hA5A5_A5A5_A5A5_A5A5, 32'd1000);
        send_request(64'hA5A5_A5A5_A5A5_A5A5, 32'd10);
        send_request(64'h5A5A_5A5A_5A5A_5A5A, 32'h8000_0000);
        send_request(64'h0123_4567_89AB_CDEF, 32'h7FFF_FFFF);

        // Zero lifetime: entries are born expired
        wait_drained();
        write_ttl(16'd0);
        send_request(64'hC3C3_0000_FFFF_3C3C, 32'd5);
        send_request(64'hC3C3_0000_FFFF_3C3C, 32'd5);
        send_request(64'hC3C3_0000_FFFF_3C3C, 32'd4);

        // Largest lifetime with overflow
        wait_drained();
        write_ttl(16'hFFFF);
        send_request(64'hFEDC_BA98_7654_3210, 32'hFFFF_0001);
        send_request(64'hFEDC_BA98_7654_3210, 32'hFFFF_FFFE);
        send_request(64'hFEDC_BA98_7654_3210, 32'hFFFF_FFFF);

        // Lifetime of one second
        wait_drained();
        write_ttl(16'd1);
        send_request(64'h3C00_0000_0000_00C3, 32'd10);
        send_request(64'h3C00_0000_0000_00C3, 32'd10);
        send_request(64'h3C00_0000_0000_00C3, 32'd11);

        // Random phases: fresh nonces, repeats of recent ones, mixed times
        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            write_ttl(phase_ttl[p][TTL_W-1:0]);
            send_idle_pct = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            wall_clock = $urandom;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                r = $urandom_range(99);
                if (r < 45 && recent_nonces.size() > 0)
                    n = recent_nonces[$urandom_range(recent_nonces.size() - 1)];
                else if (r < 55)
                    n = 64'($urandom_range(3));
                else
                    n = {$urandom, $urandom};
                r = $urandom_range(99);
                if (r < 8)
                    t = $urandom;
                else if (r < 13)
                    t = 32'hFFFF_FFFF - $urandom_range(40);
                else if (r < 20)
                    t = wall_clock - $urandom_range(30);
                else
                begin
                    wall_clock = wall_clock + $urandom_range(2);
                    t = wall_clock;
                end
                send_request(n, t);
                recent_nonces.push_back(n);
                if (recent_nonces.size() > POOL_DEPTH)
                    void'(recent_nonces.pop_front());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
